>>> design/morse_character_encoder_top_assert.svh
// Assertion macros for the Morse character encoder.
`ifndef MORSE_CHARACTER_ENCODER_TOP_ASSERT_SVH
`define MORSE_CHARACTER_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MCE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mce same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mce next-cycle check failed");

`endif

>>> design/mce_pkg.sv
// Shared types, constants and character ROM for the Morse character encoder.
`default_nettype none

package mce_pkg;

   localparam int TickW    = 16;
   localparam int ToneW    = 18;
   localparam int CharW    = 8;
   localparam int RomAddrW = 7;
   localparam int RomW     = 9;
   localparam int ElemBitsW = 6;
   localparam int ElemIdxW = 3;
   localparam int CsrDataW = 32;
   localparam int CsrAddrW = 4;
   localparam int CsrIdxW  = 2;
   localparam int QueueDepth = 2;
   localparam int QPtrW    = $clog2(QueueDepth);
   localparam int QCntW    = $clog2(QueueDepth + 1);

   // Register indexes on the configuration port
   localparam logic [CsrIdxW-1:0] CsrBitTime   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrCharDelay = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrWordDelay = 2'd2;

   localparam logic [TickW-1:0] BitTimeReset   = 16'd60;
   localparam logic [TickW-1:0] CharDelayReset = 16'd180;
   localparam logic [TickW-1:0] WordDelayReset = 16'd420;

   // Error signal: eight dits, so the last element index is seven
   localparam logic [ElemIdxW-1:0] ErrorLastIdx = 3'd7;

   typedef enum logic {
      BACK_IDLE,
      BACK_SEND
   } back_state_type;

   typedef struct packed {
      logic [ElemIdxW-1:0]  last_idx;
      logic [ElemBitsW-1:0] elem_bits;
      logic                 in_prosign;
      logic                 word_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [TickW-1:0] dit_len;
      logic [TickW-1:0] letter_gap;
      logic [TickW-1:0] word_gap;
   } cfg_type;

   // Entry: count in [8:6], element bits in [5:0], dah = 1, sent LSB first
   localparam logic [RomW-1:0] MorseRom [0:127] = '{
      9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
      9'o000, 9'o000, 9'o412, 9'o000, 9'o000, 9'o412, 9'o000, 9'o000,
      9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
      9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
      9'o000, 9'o665, 9'o622, 9'o000, 9'o000, 9'o000, 9'o502, 9'o636,
      9'o515, 9'o000, 9'o000, 9'o512, 9'o663, 9'o000, 9'o652, 9'o511,
      9'o537, 9'o536, 9'o534, 9'o530, 9'o520, 9'o500, 9'o501, 9'o503,
      9'o507, 9'o517, 9'o607, 9'o625, 9'o000, 9'o521, 9'o000, 9'o614,
      9'o000, 9'o202, 9'o401, 9'o405, 9'o301, 9'o100, 9'o404, 9'o303,
      9'o400, 9'o200, 9'o416, 9'o305, 9'o402, 9'o203, 9'o201, 9'o307,
      9'o406, 9'o413, 9'o302, 9'o300, 9'o101, 9'o304, 9'o410, 9'o306,
      9'o411, 9'o415, 9'o403, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000,
      9'o000, 9'o202, 9'o401, 9'o405, 9'o301, 9'o100, 9'o404, 9'o303,
      9'o400, 9'o200, 9'o416, 9'o305, 9'o402, 9'o203, 9'o201, 9'o307,
      9'o406, 9'o413, 9'o302, 9'o300, 9'o101, 9'o304, 9'o410, 9'o306,
      9'o411, 9'o415, 9'o403, 9'o000, 9'o000, 9'o000, 9'o000, 9'o000
   };

endpackage

`default_nettype wire

>>> design/morse_character_encoder_top.sv
// Top level of the Morse character encoder: register port, front end, queue, sequencer.
//
// Each accepted item is one text character; its low seven bits pick a ROM
// entry of up to six elements (a character with no code is sent as eight
// dits, the error signal). Every element leaves as one result item carrying
// the silence before it and its tone length (the dit length for a dit, three
// times the dit length for a dah), with last_element marking the final one.
// The silence is the dit length between elements, the letter gap after a
// character unless it is part of a prosign, and the word gap after a
// character that ends a word. The front end decodes the character in the
// cycle it is accepted and writes a command into a two-entry queue, so
// characters keep arriving while the sequencer works. The sequencer loads
// a command in its idle state and then emits one element per cycle while
// the result channel keeps up. The timing registers sit at byte addresses 0
// (dit length), 4 (letter gap) and 8 (word gap); change them only while no
// item is in flight.
`default_nettype none

module morse_character_encoder_top (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_in_prosign,
   input  logic        req_word_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_gap_ticks,
   output logic [17:0] rsp_tone_ticks,
   output logic        rsp_is_dah,
   output logic        rsp_last_element,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mce_pkg::*;

   `include "morse_character_encoder_top_assert.svh"

   logic [TickW-1:0]   dit_len_ff, dit_len_in;
   logic [TickW-1:0]   letter_gap_ff, letter_gap_in;
   logic [TickW-1:0]   word_gap_ff, word_gap_in;
   logic               csr_write;
   logic [CsrIdxW-1:0] csr_idx;
   cfg_type            cfg;
   queue_status_type   q_status;
   cmd_type            push_cmd;
   cmd_type            pop_cmd;
   logic               q_push;
   logic               q_pop;

   // Register port: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CsrAddrW-1:2];

   always_comb begin
      dit_len_in    = dit_len_ff;
      letter_gap_in = letter_gap_ff;
      word_gap_in   = word_gap_ff;
      if (csr_write) begin
         case (csr_idx)
            CsrBitTime:   dit_len_in    = csr_pwdata[TickW-1:0];
            CsrCharDelay: letter_gap_in = csr_pwdata[TickW-1:0];
            CsrWordDelay: word_gap_in   = csr_pwdata[TickW-1:0];
            default:      ; // drop writes to unmapped addresses
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dit_len_ff    <= BitTimeReset;
         letter_gap_ff <= CharDelayReset;
         word_gap_ff   <= WordDelayReset;
      end else begin
         dit_len_ff    <= dit_len_in;
         letter_gap_ff <= letter_gap_in;
         word_gap_ff   <= word_gap_in;
      end
   end

   // Read back, zero-extended; unmapped addresses read zero
   always_comb begin
      case (csr_idx)
         CsrBitTime:   csr_prdata = {{(CsrDataW-TickW){1'b0}}, dit_len_ff};
         CsrCharDelay: csr_prdata = {{(CsrDataW-TickW){1'b0}}, letter_gap_ff};
         CsrWordDelay: csr_prdata = {{(CsrDataW-TickW){1'b0}}, word_gap_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.dit_len    = dit_len_ff;
   assign cfg.letter_gap = letter_gap_ff;
   assign cfg.word_gap   = word_gap_ff;

   // Front end: decode the character and push a command
   mce_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_in_prosign (req_in_prosign),
      .req_word_end   (req_word_end),
      .q_status       (q_status),
      .push           (q_push),
      .push_cmd       (push_cmd)
   );

   // Hold decoded commands until the sequencer is free
   mce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   // Back end: advance through elements, track the pending gap
   mce_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_status         (q_status),
      .pop_cmd          (pop_cmd),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gap_ticks    (rsp_gap_ticks),
      .rsp_tone_ticks   (rsp_tone_ticks),
      .rsp_is_dah       (rsp_is_dah),
      .rsp_last_element (rsp_last_element)
   );

   // Never push into a full queue, never pop an empty one
   `MCE_ASSERT_SAME(a_no_push_full, clock, reset, q_push, !q_status.full)
   `MCE_ASSERT_SAME(a_no_pop_empty, clock, reset, q_pop, !q_status.empty)
   // An accepted item with nothing leaving must show up in the queue
   `MCE_ASSERT_NEXT(a_push_lands, clock, reset, q_push && !q_pop, !q_status.empty)

endmodule

`default_nettype wire

>>> design/mce_front.sv
// Front end: accepts characters, looks them up in the ROM and builds commands.
`default_nettype none

module mce_front (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_in_prosign,
   input  logic                       req_word_end,
   input  mce_pkg::queue_status_type  q_status,
   output logic                       push,
   output mce_pkg::cmd_type           push_cmd
);
   import mce_pkg::*;

   logic [RomW-1:0]     rom_entry;
   logic [ElemIdxW-1:0] elem_count;

   assign rom_entry  = MorseRom[req_char_code[RomAddrW-1:0]];
   assign elem_count = rom_entry[RomW-1:ElemBitsW];

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      // zero count means the error signal
      push_cmd.last_idx   = (elem_count == '0) ? ErrorLastIdx : elem_count - 1'b1;
      push_cmd.elem_bits  = rom_entry[ElemBitsW-1:0];
      push_cmd.in_prosign = req_in_prosign;
      push_cmd.word_end   = req_word_end;
   end

endmodule

`default_nettype wire

>>> design/mce_queue.sv
// Short command queue between the front end and the element sequencer.
`default_nettype none

module mce_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mce_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output mce_pkg::cmd_type           pop_cmd,
   output mce_pkg::queue_status_type  q_status
);
   import mce_pkg::*;

   cmd_type          slot_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] fill_ff, fill_in;

   assign q_status.full  = (fill_ff == QCntW'(QueueDepth));
   assign q_status.empty = (fill_ff == '0);
   assign pop_cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> design/mce_back.sv
// Back end: steps through the elements of one character and emits results.
`default_nettype none

module mce_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mce_pkg::cfg_type           cfg,
   input  mce_pkg::queue_status_type  q_status,
   input  mce_pkg::cmd_type           pop_cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_gap_ticks,
   output logic [17:0]                rsp_tone_ticks,
   output logic                       rsp_is_dah,
   output logic                       rsp_last_element
);
   import mce_pkg::*;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ElemIdxW-1:0]  elem_ff, elem_in;
   logic [TickW-1:0]     gap_ff, gap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TickW-1:0]     rsp_gap_ff, rsp_gap_in;
   logic [ToneW-1:0]     rsp_tone_ff, rsp_tone_in;
   logic                 rsp_dah_ff, rsp_dah_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 out_free;
   logic                 is_last;
   logic [ToneW-1:0]     dit_tone;
   logic [ToneW-1:0]     dah_tone;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = (elem_ff == cmd_ff.last_idx);
   assign dit_tone = {2'b00, cfg.dit_len};
   assign dah_tone = {2'b00, cfg.dit_len} + {1'b0, cfg.dit_len, 1'b0};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      elem_in      = elem_ff;
      gap_in       = gap_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_gap_in   = rsp_gap_ff;
      rsp_tone_in  = rsp_tone_ff;
      rsp_dah_in   = rsp_dah_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cmd_in   = pop_cmd;
               elem_in  = '0;
               state_in = BACK_SEND;
            end
         end
         BACK_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_gap_in   = gap_ff;
               rsp_dah_in   = cmd_ff.elem_bits[0];
               rsp_tone_in  = cmd_ff.elem_bits[0] ? dah_tone : dit_tone;
               rsp_last_in  = is_last;
               cmd_in.elem_bits = cmd_ff.elem_bits >> 1;
               elem_in      = elem_ff + 1'b1;
               gap_in       = cfg.dit_len;
               if (is_last) begin
                  if (!cmd_ff.in_prosign) begin
                     gap_in = cfg.letter_gap;
                  end
                  if (cmd_ff.word_end) begin
                     gap_in = cfg.word_gap;
                  end
                  state_in = BACK_IDLE;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         elem_ff      <= '0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elem_ff      <= elem_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_gap_ff  <= rsp_gap_in;
      rsp_tone_ff <= rsp_tone_in;
      rsp_dah_ff  <= rsp_dah_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gap_ticks    = rsp_gap_ff;
   assign rsp_tone_ticks   = rsp_tone_ff;
   assign rsp_is_dah       = rsp_dah_ff;
   assign rsp_last_element = rsp_last_ff;

endmodule

`default_nettype wire
